// ----- hdl/assert_macros.svh -----
// Assertion helpers; every use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NEVER(lbl, expr)
`define ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ----- hdl/sdr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sdr_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SHARP_BOOST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_BOOST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MID_BOOST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_BOOST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_STEP  = 3'd6;

    localparam logic [7:0] RST_SHARP_BOOST = 8'd160;
    localparam logic [7:0] RST_HARD_BOOST  = 8'd150;
    localparam logic [7:0] RST_MID_BOOST   = 8'd145;
    localparam logic [7:0] RST_LIGHT_BOOST = 8'd135;
    localparam logic [7:0] RST_MIN_RUN     = 8'd100;
    localparam logic [6:0] RST_SPEED_STEP  = 7'd18;
    localparam logic [5:0] RST_SERVO_STEP  = 6'd8;

    localparam logic [7:0] SERVO_MIN    = 8'd40;
    localparam logic [7:0] SERVO_MAX    = 8'd140;
    localparam logic [7:0] SERVO_CENTER = 8'd90;

    localparam logic [7:0] DEV_SHARP = 8'd35;
    localparam logic [7:0] DEV_HARD  = 8'd25;
    localparam logic [7:0] DEV_TURN  = 8'd15;
    localparam logic [7:0] DEV_LIGHT = 8'd10;

    // Ratio numerator over a denominator of 60000
    localparam int NW = 20;
    localparam logic signed [NW-1:0] RATIO_DEN  = 20'sd60000;
    localparam logic signed [NW-1:0] GAIN_FULL  = 20'sd1000;
    localparam logic signed [NW-1:0] GAIN_DAMP  = 20'sd700;
    localparam logic signed [NW-1:0] GAIN_ROLL  = 20'sd18;
    localparam logic signed [NW-1:0] GAIN_DOWN  = 20'sd30;
    localparam logic signed [NW-1:0] GAIN_UP    = 20'sd18;
    localparam logic signed [NW-1:0] PITCH_DEAD = 20'sd100;
    localparam logic signed [14:0]   LAT_LIMIT  = 15'sd500;

    // q = (mag*16384 + 30000) / 60000 = (mag*512 + 937) / 1875
    localparam logic [24:0] DIV_BIAS    = 25'd937;
    localparam logic [24:0] DIV_CONST   = 25'd1875;
    localparam logic [14:0] RECIP_M     = 15'd17895;
    localparam int          RECIP_SHIFT = 25;
    localparam logic [14:0] RATIO_ONE   = 15'd16384;

    localparam logic signed [9:0] SPEED_LIM = 10'sd255;

    typedef struct packed {
        logic [7:0] sharp_boost;
        logic [7:0] hard_boost;
        logic [7:0] mid_boost;
        logic [7:0] light_boost;
        logic [7:0] min_run;
        logic [6:0] speed_step;
        logic [5:0] servo_step;
    } sdr_cfg_t;

    typedef struct packed {
        logic [7:0]        servo_angle;
        logic signed [8:0] boosted_target;
        logic              ratio_neg;
        logic [15:0]       ratio_mag;
    } sdr_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sdr_q_stat_t;

endpackage

`default_nettype wire

// ----- hdl/sdr_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdr_cfg
    import sdr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output sdr_cfg_t                   cfg
);

    sdr_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sharp_boost <= RST_SHARP_BOOST;
            cfg_reg.hard_boost  <= RST_HARD_BOOST;
            cfg_reg.mid_boost   <= RST_MID_BOOST;
            cfg_reg.light_boost <= RST_LIGHT_BOOST;
            cfg_reg.min_run     <= RST_MIN_RUN;
            cfg_reg.speed_step  <= RST_SPEED_STEP;
            cfg_reg.servo_step  <= RST_SERVO_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SHARP_BOOST: cfg_reg.sharp_boost <= cfg_data;
                REG_HARD_BOOST:  cfg_reg.hard_boost  <= cfg_data;
                REG_MID_BOOST:   cfg_reg.mid_boost   <= cfg_data;
                REG_LIGHT_BOOST: cfg_reg.light_boost <= cfg_data;
                REG_MIN_RUN:     cfg_reg.min_run     <= cfg_data;
                REG_SPEED_STEP:  cfg_reg.speed_step  <= cfg_data[6:0];
                REG_SERVO_STEP:  cfg_reg.servo_step  <= cfg_data[5:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/sdr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdr_front
    import sdr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  sdr_cfg_t                cfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [8:0]  target_speed,
    input  wire logic [7:0]         target_angle,
    input  wire logic signed [11:0] roll_tenths,
    input  wire logic signed [11:0] pitch_tenths,
    input  wire logic signed [14:0] lateral_accel,
    input  sdr_q_stat_t             q_stat,
    output logic                    push,
    output sdr_item_t               push_item
);

    logic [7:0]         servo_reg;
    logic [7:0]         servo_next;
    logic               hold_vld_reg;
    logic               hold_vld_next;
    logic [7:0]         h_servo_reg;
    logic signed [8:0]  h_tgt_reg;
    logic signed [11:0] h_roll_reg;
    logic signed [11:0] h_pitch_reg;
    logic signed [14:0] h_lat_reg;

    logic               accept;
    logic signed [9:0]  srv_cur;
    logic signed [9:0]  srv_step;
    logic signed [9:0]  srv_wide;
    logic [7:0]         dev;
    logic               floor_en;
    logic [7:0]         floor_v;
    logic signed [9:0]  tgt0;
    logic signed [9:0]  tgt1;
    logic signed [9:0]  tgt2;
    logic signed [9:0]  floor_s;
    logic signed [9:0]  mr_s;

    logic signed [8:0]    dev_s;
    logic signed [NW-1:0] dev_x;
    logic signed [NW-1:0] roll_x;
    logic signed [NW-1:0] pitch_x;
    logic signed [NW-1:0] term_d;
    logic signed [NW-1:0] term_p;
    logic signed [NW-1:0] n_sum;
    logic signed [NW-1:0] n_clamp;
    logic signed [NW-1:0] n_abs;
    logic                 lat_big;

    assign push     = hold_vld_reg && !q_stat.full;
    assign in_stall = hold_vld_reg && q_stat.full;
    assign accept   = in_valid && !in_stall;

    // servo slew and clamp
    always_comb
    begin
        srv_cur  = signed'({2'b00, servo_reg});
        srv_step = signed'({4'b0000, cfg.servo_step});
        if (servo_reg < target_angle)
            srv_wide = srv_cur + srv_step;
        else if (servo_reg > target_angle)
            srv_wide = srv_cur - srv_step;
        else
            srv_wide = srv_cur;

        if (srv_wide < signed'({2'b00, SERVO_MIN}))
            servo_next = SERVO_MIN;
        else if (srv_wide > signed'({2'b00, SERVO_MAX}))
            servo_next = SERVO_MAX;
        else
            servo_next = srv_wide[7:0];
    end

    // boost floor by deviation, then minimum run
    always_comb
    begin
        dev = (servo_next >= SERVO_CENTER) ? servo_next - SERVO_CENTER
                                           : SERVO_CENTER - servo_next;
        floor_en = 1'b1;
        if (dev > DEV_SHARP)
            floor_v = cfg.sharp_boost;
        else if (dev > DEV_HARD)
            floor_v = cfg.hard_boost;
        else if (dev > DEV_TURN)
            floor_v = cfg.mid_boost;
        else if (dev > DEV_LIGHT)
            floor_v = cfg.light_boost;
        else
        begin
            floor_v  = 8'd0;
            floor_en = 1'b0;
        end

        tgt0    = {target_speed[8], target_speed};
        floor_s = signed'({2'b00, floor_v});
        mr_s    = signed'({2'b00, cfg.min_run});

        if (floor_en && tgt0 > 10'sd0 && tgt0 < floor_s)
            tgt1 = floor_s;
        else
            tgt1 = tgt0;

        if (tgt1 > 10'sd0 && tgt1 < mr_s)
            tgt2 = mr_s;
        else if (tgt1 < 10'sd0 && tgt1 > -mr_s)
            tgt2 = -mr_s;
        else
            tgt2 = tgt1;
    end

    // steering ratio numerator from the held item
    always_comb
    begin
        dev_s   = signed'({1'b0, h_servo_reg}) - signed'({1'b0, SERVO_CENTER});
        dev_x   = {{(NW-9){dev_s[8]}}, dev_s};
        roll_x  = {{(NW-12){h_roll_reg[11]}}, h_roll_reg};
        pitch_x = {{(NW-12){h_pitch_reg[11]}}, h_pitch_reg};
        lat_big = (h_lat_reg > LAT_LIMIT) || (h_lat_reg < -LAT_LIMIT);

        term_d = dev_x * (lat_big ? GAIN_DAMP : GAIN_FULL);

        if (pitch_x < -PITCH_DEAD)
            term_p = (-pitch_x - PITCH_DEAD) * GAIN_DOWN;
        else if (pitch_x > PITCH_DEAD)
            term_p = -((pitch_x - PITCH_DEAD) * GAIN_UP);
        else
            term_p = '0;

        n_sum = term_d + roll_x * GAIN_ROLL + term_p;

        if (n_sum > RATIO_DEN)
            n_clamp = RATIO_DEN;
        else if (n_sum < -RATIO_DEN)
            n_clamp = -RATIO_DEN;
        else
            n_clamp = n_sum;

        n_abs = n_clamp[NW-1] ? -n_clamp : n_clamp;

        push_item.servo_angle    = h_servo_reg;
        push_item.boosted_target = h_tgt_reg;
        push_item.ratio_neg      = n_clamp[NW-1];
        push_item.ratio_mag      = n_abs[15:0];
    end

    always_comb
    begin
        if (accept)
            hold_vld_next = 1'b1;
        else if (push)
            hold_vld_next = 1'b0;
        else
            hold_vld_next = hold_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_reg    <= SERVO_CENTER;
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
            if (accept)
                servo_reg <= servo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h_servo_reg <= servo_next;
            h_tgt_reg   <= tgt2[8:0];
            h_roll_reg  <= roll_tenths;
            h_pitch_reg <= pitch_tenths;
            h_lat_reg   <= lateral_accel;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sdr_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdr_fifo
    import sdr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  sdr_item_t  push_item,
    input  wire logic  pop,
    output sdr_item_t  pop_item,
    output sdr_q_stat_t q_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sdr_item_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pop_item     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ----- hdl/sdr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdr_back
    import sdr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [6:0]  speed_step,
    input  sdr_q_stat_t      q_stat,
    output logic             pop,
    input  sdr_item_t        pop_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       servo_angle,
    output logic signed [8:0] boosted_target,
    output logic signed [8:0] left_speed,
    output logic signed [8:0] right_speed,
    output logic [7:0]       fwd_duty,
    output logic [7:0]       rev_duty
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_CORR,
        B_RED,
        B_OUT
    } b_state_t;

    b_state_t          state_reg;
    logic signed [9:0] speed_reg;
    sdr_item_t         it_reg;
    logic [24:0]       y_reg;
    logic [39:0]       prod_reg;
    logic [14:0]       qe_reg;
    logic [11:0]       rem_reg;
    logic [8:0]        red_reg;
    logic              qpos_reg;
    logic              out_valid_reg;

    logic [7:0]        servo_out_reg;
    logic signed [8:0] tgt_out_reg;
    logic signed [8:0] left_out_reg;
    logic signed [8:0] right_out_reg;
    logic [7:0]        fwd_out_reg;
    logic [7:0]        rev_out_reg;

    logic               load_out;
    logic [24:0]        y_in;
    logic signed [10:0] spd11;
    logic signed [10:0] tgt11;
    logic signed [10:0] ramp11;
    logic [14:0]        qe;
    logic [24:0]        qmul;
    logic [24:0]        rem_full;
    logic [14:0]        qmag;
    logic [14:0]        frac;
    logic [8:0]         abs_s;
    logic [23:0]        red_prod;

    logic signed [9:0]  red_s;
    logic               left_red;
    logic signed [9:0]  l10;
    logic signed [9:0]  r10;
    logic signed [8:0]  l9;
    logic signed [8:0]  r9;
    logic signed [8:0]  mx;
    logic signed [8:0]  mn;
    logic [8:0]         amx;
    logic [8:0]         amn;
    logic [7:0]         fwd_v;
    logic [7:0]         rev_v;

    assign pop      = (state_reg == B_IDLE) && !q_stat.empty;
    assign load_out = (state_reg == B_OUT) && (!out_valid_reg || !out_stall);

    // speed ramp and the first reciprocal product, taken at pop
    always_comb
    begin
        y_in  = {pop_item.ratio_mag, 9'd0} + DIV_BIAS;
        spd11 = {speed_reg[9], speed_reg};
        tgt11 = {{2{pop_item.boosted_target[8]}}, pop_item.boosted_target};
        if (spd11 < tgt11)
            ramp11 = spd11 + signed'({4'b0000, speed_step});
        else if (spd11 > tgt11)
            ramp11 = spd11 - signed'({4'b0000, speed_step});
        else
            ramp11 = spd11;
    end

    // quotient estimate is low by at most one; the remainder fixes it
    always_comb
    begin
        qe       = prod_reg[RECIP_SHIFT +: 15];
        qmul     = {10'd0, qe} * DIV_CONST;
        rem_full = y_reg - qmul;
        qmag     = qe_reg + {14'd0, ({13'd0, rem_reg} >= DIV_CONST)};
        frac     = RATIO_ONE - qmag;
        abs_s    = speed_reg[9] ? 9'(-speed_reg) : speed_reg[8:0];
        red_prod = {15'd0, abs_s} * {9'd0, frac};
    end

    // wheel split, clamp and duties
    always_comb
    begin
        red_s    = speed_reg[9] ? -signed'({1'b0, red_reg}) : signed'({1'b0, red_reg});
        left_red = (speed_reg > 10'sd0) == qpos_reg;
        l10      = left_red ? red_s : speed_reg;
        r10      = left_red ? speed_reg : red_s;

        if (speed_reg == 10'sd0)
        begin
            l9 = '0;
            r9 = '0;
        end
        else
        begin
            l9 = (l10 > SPEED_LIM) ? 9'sd255 : ((l10 < -SPEED_LIM) ? -9'sd255 : l10[8:0]);
            r9 = (r10 > SPEED_LIM) ? 9'sd255 : ((r10 < -SPEED_LIM) ? -9'sd255 : r10[8:0]);
        end

        mx  = (l9 > r9) ? l9 : r9;
        mn  = (l9 < r9) ? l9 : r9;
        amx = mx[8] ? 9'(-mx) : mx;
        amn = mn[8] ? 9'(-mn) : mn;

        fwd_v = 8'd0;
        rev_v = 8'd0;
        if (mx > 9'sd0 && mn >= 9'sd0)
            fwd_v = mx[7:0];
        else if (mn < 9'sd0 && mx <= 9'sd0)
            rev_v = amn[7:0];
        else if (amx > amn)
            fwd_v = amx[7:0];
        else
            rev_v = amn[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        speed_reg <= ramp11[9:0];
                        state_reg <= B_CORR;
                    end
                end
                B_CORR:  state_reg <= B_RED;
                B_RED:   state_reg <= B_OUT;
                B_OUT:
                begin
                    if (load_out)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            it_reg   <= pop_item;
            y_reg    <= y_in;
            prod_reg <= {15'd0, y_in} * {25'd0, RECIP_M};
        end
        if (state_reg == B_CORR)
        begin
            qe_reg  <= qe;
            rem_reg <= rem_full[11:0];
        end
        if (state_reg == B_RED)
        begin
            red_reg  <= red_prod[22:14];
            qpos_reg <= !it_reg.ratio_neg && (qmag != 15'd0);
        end
        if (load_out)
        begin
            servo_out_reg <= it_reg.servo_angle;
            tgt_out_reg   <= it_reg.boosted_target;
            left_out_reg  <= l9;
            right_out_reg <= r9;
            fwd_out_reg   <= fwd_v;
            rev_out_reg   <= rev_v;
        end
    end

    assign out_valid      = out_valid_reg;
    assign servo_angle    = servo_out_reg;
    assign boosted_target = tgt_out_reg;
    assign left_speed     = left_out_reg;
    assign right_speed    = right_out_reg;
    assign fwd_duty       = fwd_out_reg;
    assign rev_duty       = rev_out_reg;

endmodule

`default_nettype wire

// ----- hdl/steering_speed_ramp_drive.sv -----
// An accepted transaction passes the front-end hold register, the queue, the four-step
// back-end sequencer (pop and ramp, quotient correction, wheel reduction, output load)
// and the output registers; the back end pops the next transaction only after output load.
// Front end takes a new transaction each cycle while the queue has room.
// Reset: asynchronous active low; servo angle 90, current speed 0, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module steering_speed_ramp_drive
    import sdr_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic signed [8:0]     target_speed,
    input  wire logic [7:0]            target_angle,
    input  wire logic signed [11:0]    roll_tenths,
    input  wire logic signed [11:0]    pitch_tenths,
    input  wire logic signed [14:0]    lateral_accel,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 servo_angle,
    output logic signed [8:0]          boosted_target,
    output logic signed [8:0]          left_speed,
    output logic signed [8:0]          right_speed,
    output logic [7:0]                 fwd_duty,
    output logic [7:0]                 rev_duty
);

    sdr_cfg_t    cfg;
    sdr_q_stat_t q_stat;
    sdr_item_t   push_item;
    sdr_item_t   pop_item;
    logic        push;
    logic        pop;

    sdr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .target_speed  (target_speed),
        .target_angle  (target_angle),
        .roll_tenths   (roll_tenths),
        .pitch_tenths  (pitch_tenths),
        .lateral_accel (lateral_accel),
        .q_stat        (q_stat),
        .push          (push),
        .push_item     (push_item)
    );

    sdr_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    sdr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .speed_step     (cfg.speed_step),
        .q_stat         (q_stat),
        .pop            (pop),
        .pop_item       (pop_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .servo_angle    (servo_angle),
        .boosted_target (boosted_target),
        .left_speed     (left_speed),
        .right_speed    (right_speed),
        .fwd_duty       (fwd_duty),
        .rev_duty       (rev_duty)
    );

    `ASSERT_NEVER(a_q_no_overflow, push && q_stat.full)
    `ASSERT_IMPL(a_pop_nonempty, pop, !q_stat.empty)
    `ASSERT_IMPL(a_servo_range, out_valid, (servo_angle >= SERVO_MIN) && (servo_angle <= SERVO_MAX))
    `ASSERT_NEVER(a_duty_exclusive, out_valid && (fwd_duty != 8'd0) && (rev_duty != 8'd0))

endmodule

`default_nettype wire
